// ===== rtl/core/plv_pkg.sv =====
// Shared types and constants for the playlist line validator.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package plv_pkg;

    localparam int NAME_BYTES = 64;
    localparam int URL_BYTES  = 256;
    localparam int ICON_BYTES = 64;
    localparam int MAX_COLS   = 4;
    localparam int NUM_MAX    = 12;
    localparam int BREAK_CAP  = 1023;

    localparam int NAME_W  = $clog2(NAME_BYTES + 1);
    localparam int URL_W   = $clog2(URL_BYTES + 1);
    localparam int ICON_W  = $clog2(ICON_BYTES + 1);
    localparam int COL_W   = $clog2(MAX_COLS + 1);
    localparam int THIRD_W = $clog2(NUM_MAX + 2);
    localparam int BREAK_W = $clog2(BREAK_CAP + 1);
    localparam int BYTE_W  = 8;

    localparam int CAP_A   = (NAME_BYTES > URL_BYTES) ? NAME_BYTES : URL_BYTES;
    localparam int CAP_B   = (ICON_BYTES > NUM_MAX + 1) ? ICON_BYTES : NUM_MAX + 1;
    localparam int CAP_MAX = (CAP_A > CAP_B) ? CAP_A : CAP_B;
    localparam int SUM_W   = $clog2(CAP_MAX + BREAK_CAP + 2);

    localparam int OUT_BITS = 3 + COL_W + NAME_W + URL_W + ICON_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [COL_W-1:0] COL_NAME  = COL_W'(0);
    localparam logic [COL_W-1:0] COL_URL   = COL_W'(1);
    localparam logic [COL_W-1:0] COL_THIRD = COL_W'(2);
    localparam logic [COL_W-1:0] COL_ICON  = COL_W'(3);
    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(MAX_COLS);

    localparam logic [BYTE_W-1:0] CH_TAB        = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF         = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR         = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_S          = 8'h53;
    localparam logic [BYTE_W-1:0] CH_L          = 8'h4C;
    localparam logic [BYTE_W-1:0] CH_DOT        = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_PLUS       = 8'h2B;

    typedef enum logic [1:0] {
        NP_NONE   = 2'd0,
        NP_SIGN   = 2'd1,
        NP_DIGITS = 2'd2,
        NP_BAD    = 2'd3
    } num_progress_t;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              last_byte;
    } plv_item_t;

    typedef struct packed {
        logic [COL_W-1:0]   column_index;
        logic [NAME_W-1:0]  first_length;
        logic [URL_W-1:0]   second_length;
        logic [THIRD_W-1:0] third_length;
        logic [BYTE_W-1:0]  third_first_char;
        num_progress_t      number_progress;
        logic [ICON_W-1:0]  fourth_length;
        logic               picture_ok;
        logic [BREAK_W-1:0] pending_breaks;
    } plv_state_t;

    localparam plv_state_t STATE_RESET = '{
        column_index:     '0,
        first_length:     '0,
        second_length:    '0,
        third_length:     '0,
        third_first_char: '0,
        number_progress:  NP_NONE,
        fourth_length:    '0,
        picture_ok:       1'b1,
        pending_breaks:   '0
    };

endpackage

// ===== rtl/core/plv_in_stage.sv =====
// Input register of the playlist line validator: holds one byte transaction.
// Depends on plv_pkg.
`timescale 1ns / 1ps

module plv_in_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [plv_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] line_byte
    input  logic                       s_axis_tlast,
    input  logic                       advance,
    output logic                       item_valid,
    output plv_pkg::plv_item_t         item
);
    import plv_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    plv_item_t item_reg;
    logic      accept;

    assign s_axis_tready = !valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.line_byte <= s_axis_tdata;
            item_reg.last_byte <= s_axis_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/plv_tracker.sv =====
// Column tracker: per-byte update of column counters, number and picture checks.
// Depends on plv_pkg.
`timescale 1ns / 1ps

module plv_tracker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  plv_pkg::plv_item_t  item,
    output plv_pkg::plv_state_t st_next
);
    import plv_pkg::*;

    plv_state_t          st_reg;
    plv_state_t          nx;
    logic                is_break;
    logic                is_tab;
    logic                is_content;
    logic                has_pend;
    logic [SUM_W-1:0]    pend_ext;
    logic [SUM_W-1:0]    inc;
    logic [SUM_W-1:0]    first_sum;
    logic [SUM_W-1:0]    second_sum;
    logic [SUM_W-1:0]    third_sum;
    logic [SUM_W-1:0]    fourth_sum;
    logic [THIRD_W-1:0]  tl_mid;
    num_progress_t       np_mid;
    logic [BYTE_W-1:0]   tfc_mid;
    logic                icon_empty_mid;

    function automatic logic [SUM_W-1:0] sat(input logic [SUM_W-1:0] s,
                                             input logic [SUM_W-1:0] cap);
        return (s > cap) ? cap : s;
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_pic_char(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               is_digit(c) || (c == CH_DOT) || (c == CH_MINUS) || (c == CH_UNDERSCORE);
    endfunction

    assign is_break   = (item.line_byte == CH_CR) || (item.line_byte == CH_LF);
    assign is_tab     = (item.line_byte == CH_TAB);
    assign is_content = !is_break && !is_tab;
    assign has_pend   = (st_reg.pending_breaks != '0);
    assign pend_ext   = SUM_W'(st_reg.pending_breaks);
    assign inc        = SUM_W'(is_content);

    assign first_sum  = sat(SUM_W'(st_reg.first_length) + pend_ext + inc, SUM_W'(NAME_BYTES));
    assign second_sum = sat(SUM_W'(st_reg.second_length) + pend_ext + inc, SUM_W'(URL_BYTES));
    assign third_sum  = sat(SUM_W'(st_reg.third_length) + pend_ext + inc, SUM_W'(NUM_MAX + 1));
    assign fourth_sum = sat(SUM_W'(st_reg.fourth_length) + pend_ext + inc, SUM_W'(ICON_BYTES));

    // flushed breaks are applied before the current byte
    assign tl_mid  = has_pend ? third_sum[THIRD_W-1:0] : st_reg.third_length;
    assign np_mid  = has_pend ? NP_BAD : st_reg.number_progress;
    assign tfc_mid = (has_pend && (st_reg.third_length == '0)) ? '0 : st_reg.third_first_char;
    assign icon_empty_mid = (st_reg.fourth_length == '0) && !has_pend;

    always_comb
    begin
        nx = st_reg;
        if (is_break)
        begin
            if (st_reg.pending_breaks != BREAK_W'(BREAK_CAP))
            begin
                nx.pending_breaks = st_reg.pending_breaks + BREAK_W'(1);
            end
        end
        else
        begin
            nx.pending_breaks = '0;
            if (is_tab && (st_reg.column_index < COL_LIMIT))
            begin
                nx.column_index = st_reg.column_index + COL_W'(1);
            end
            unique case (st_reg.column_index)
                COL_NAME:
                begin
                    nx.first_length = first_sum[NAME_W-1:0];
                end
                COL_URL:
                begin
                    nx.second_length = second_sum[URL_W-1:0];
                end
                COL_THIRD:
                begin
                    nx.third_length     = third_sum[THIRD_W-1:0];
                    nx.number_progress  = np_mid;
                    nx.third_first_char = tfc_mid;
                    if (is_content)
                    begin
                        if (tl_mid == '0)
                        begin
                            nx.third_first_char = item.line_byte;
                            if ((item.line_byte == CH_MINUS) || (item.line_byte == CH_PLUS))
                            begin
                                nx.number_progress = NP_SIGN;
                            end
                            else if (is_digit(item.line_byte))
                            begin
                                nx.number_progress = NP_DIGITS;
                            end
                            else
                            begin
                                nx.number_progress = NP_BAD;
                            end
                        end
                        else if (np_mid != NP_BAD)
                        begin
                            nx.number_progress = is_digit(item.line_byte) ? NP_DIGITS : NP_BAD;
                        end
                    end
                end
                COL_ICON:
                begin
                    nx.fourth_length = fourth_sum[ICON_W-1:0];
                    if (has_pend || (is_content && (!is_pic_char(item.line_byte) ||
                        (icon_empty_mid && (item.line_byte == CH_DOT)))))
                    begin
                        nx.picture_ok = 1'b0;
                    end
                end
                default:
                begin
                    // fifth column and beyond: drop content
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            st_reg <= item.last_byte ? STATE_RESET : nx;
        end
    end

    assign st_next = nx;

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.last_byte) |=> (st_reg.column_index == '0) &&
            (st_reg.pending_breaks == '0) && st_reg.picture_ok)
        else $error("tracker state not cleared after last byte");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.column_index <= COL_LIMIT)
        else $error("column index beyond saturation");

    a_third_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.third_length <= THIRD_W'(NUM_MAX + 1))
        else $error("third column length beyond saturation");
`endif

endmodule

// ===== rtl/core/plv_out_stage.sv =====
// Verdict logic and result register of the playlist line validator.
// Depends on plv_pkg; fed by plv_tracker and plv_in_stage.
`timescale 1ns / 1ps

module plv_out_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  logic                      item_last,
    input  plv_pkg::plv_state_t       nx,
    output logic                      advance,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [0] line_valid, [1] name_from_list, [2] own_dialect, [5:3] column_count,
    // [12:6] name_length, [21:13] url_length, [28:22] icon_length
    output logic [plv_pkg::OUT_W-1:0] m_axis_tdata
);
    import plv_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [OUT_W-1:0]  data_reg;
    logic [OUT_W-1:0]  data_next;
    logic              own;
    logic              from_list;
    logic              base_ok;
    logic              line_ok;
    logic [COL_W-1:0]  cols;
    logic [ICON_W-1:0] icon_len;
    logic              load;

    assign advance = item_valid && (!item_last || !valid_reg || m_axis_tready);
    assign load    = advance && item_last;

    assign own = (nx.column_index >= COL_THIRD) && (nx.third_length == THIRD_W'(1)) &&
                 ((nx.third_first_char == CH_S) || (nx.third_first_char == CH_L));
    assign from_list = own && (nx.third_first_char == CH_L);

    assign base_ok = (nx.column_index != COL_NAME) && (nx.column_index <= COL_ICON) &&
                     (nx.first_length != '0) && (nx.first_length < NAME_W'(NAME_BYTES)) &&
                     (nx.second_length != '0) && (nx.second_length < URL_W'(URL_BYTES));

    always_comb
    begin
        line_ok  = base_ok;
        icon_len = '0;
        if (own)
        begin
            if (nx.column_index == COL_ICON)
            begin
                icon_len = nx.fourth_length;
                if ((nx.fourth_length != '0) &&
                    ((nx.fourth_length >= ICON_W'(ICON_BYTES)) || !nx.picture_ok))
                begin
                    line_ok = 1'b0;
                end
            end
        end
        else
        begin
            if (nx.column_index == COL_ICON)
            begin
                line_ok = 1'b0;
            end
            if ((nx.column_index == COL_THIRD) && (nx.third_length != '0) &&
                ((nx.third_length > THIRD_W'(NUM_MAX)) || (nx.number_progress != NP_DIGITS)))
            begin
                line_ok = 1'b0;
            end
        end
    end

    assign cols = (nx.column_index >= COL_LIMIT) ? COL_LIMIT : nx.column_index + COL_W'(1);

    assign data_next = OUT_W'({icon_len, nx.second_length, nx.first_length, cols,
                               own, from_list, line_ok});

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

`ifndef NO_ASSERTIONS
    a_adv_item: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> item_valid)
        else $error("advance without a held byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !m_axis_tready) |-> !load)
        else $error("result register overwritten while stalled");

    a_cols_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg[3 +: COL_W] != '0) && (data_reg[3 +: COL_W] <= COL_LIMIT))
        else $error("column count out of range");
`endif

endmodule

// ===== rtl/core/playlist_line_validator_core.sv =====
// Top level of the playlist line validator: input register, tracker, verdict.
// Depends on plv_pkg, plv_in_stage, plv_tracker and plv_out_stage.
`timescale 1ns / 1ps

// One byte transaction is taken per clock cycle unless the input side stalls;
// the limit is the combinational counter and flag update in the tracker
// between the input register and the state registers. No transaction is
// produced for bytes without tlast; the verdict for the byte with tlast is
// loaded into the result register as that byte leaves the input register.
// The input side stalls only when a last byte arrives while the previous
// verdict waits in the result register. State clears after every last byte.
module playlist_line_validator_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [plv_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] line_byte
    input  logic                       s_axis_tlast,   // last_byte
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [0] line_valid, [1] name_from_list, [2] own_dialect, [5:3] column_count,
    // [12:6] name_length, [21:13] url_length, [28:22] icon_length, rest zero
    output logic [plv_pkg::OUT_W-1:0]  m_axis_tdata
);
    import plv_pkg::*;

    logic       advance;
    logic       item_valid;
    plv_item_t  item;
    plv_state_t st_next;

    plv_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    plv_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .st_next (st_next)
    );

    plv_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_last     (item.last_byte),
        .nx            (st_next),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
